@@ rtl/dcp_pkg.sv @@
// daisy-chain pec15 checker: shared constants, register codes, types
// and the bytewise crc-15 functions used by the config and frame logic
// no dependencies
package dcp_pkg;

    localparam int MAX_DEVICES     = 8;
    localparam int MAX_GROUP_BYTES = 64;

    localparam int BYTE_W     = 8;
    localparam int CRC_W      = 15;
    localparam int PEC_W      = 16;
    localparam int POS_W      = 7;
    localparam int DEV_W      = 4;
    localparam int IDX_W      = 3;
    localparam int MASK_W     = MAX_DEVICES;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_POLY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IC_COUNT = 2'd3;

    localparam logic [CRC_W-1:0] POLY_RST     = 15'h4599;
    localparam logic [CRC_W-1:0] SEED_RST     = 15'd16;
    localparam logic [POS_W-1:0] GROUP_RST    = 7'd6;
    localparam logic [DEV_W-1:0] IC_COUNT_RST = 4'd1;

    // saturated configuration as seen by the frame logic
    typedef struct packed {
        logic [CRC_W-1:0] poly;
        logic [CRC_W-1:0] seed;
        logic [POS_W-1:0] group_len;
        logic [DEV_W-1:0] ic_count;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]  ic_index;
        logic              pec_ok;
        logic [PEC_W-1:0]  computed_pec;
        logic [MASK_W-1:0] error_mask;
        logic              last;
    } result_t;

    // remainder of one byte pushed through eight msb-first steps
    function automatic logic [CRC_W-1:0] crc_byte_term(input logic [BYTE_W-1:0] a,
                                                       input logic [CRC_W-1:0] poly);
        logic [CRC_W-1:0] r;
        r = {a, 7'd0};
        for (int k = 0; k < BYTE_W; k++) begin
            if (r[CRC_W-1])
                r = {r[CRC_W-2:0], 1'b0} ^ poly;
            else
                r = {r[CRC_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b,
                                                    input logic [CRC_W-1:0] poly);
        logic [BYTE_W-1:0] addr;
        addr = crc[CRC_W-1:CRC_W-BYTE_W] ^ b;
        return {crc[CRC_W-BYTE_W-1:0], 8'd0} ^ crc_byte_term(addr, poly);
    endfunction

endpackage

@@ rtl/dcp_rx_if.sv @@
// received byte channel: valid/ready handshake with frame-start flag
// depends on dcp_pkg
interface dcp_rx_if import dcp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              first;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output first, output rx_byte, input ready);
    modport sink   (input valid, input first, input rx_byte, output ready);
endinterface

@@ rtl/dcp_res_if.sv @@
// result channel: one request per completed device group
// depends on dcp_pkg
interface dcp_res_if import dcp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  ic_index;
    logic              pec_ok;
    logic [PEC_W-1:0]  computed_pec;
    logic [MASK_W-1:0] error_mask;
    logic              last;

    modport source (output valid, output ic_index, output pec_ok, output computed_pec,
                    output error_mask, output last, input ready);
    modport sink   (input valid, input ic_index, input pec_ok, input computed_pec,
                    input error_mask, input last, output ready);
endinterface

@@ rtl/dcp_cfg_if.sv @@
// configuration write channel: register index and write data
// depends on dcp_pkg
interface dcp_cfg_if import dcp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/daisy_chain_pec15_checker.sv @@
// daisy-chain pec15 checker top level: input register, frame core, result register
// depends on dcp_pkg, the channel interfaces, dcp_cfg_regs and dcp_frame_core
//
// usage
//   rx  : received bytes, one request per byte; first=1 starts a new frame
//   res : one request per device group, after its second pec byte
//   cfg : register writes (poly, seed, group length, device count), always ready;
//         write only while no byte is in flight
// latency: a byte accepted at edge n gives its result at edge n+2 (input
//   register, then the crc/compare logic into the result register)
// throughput: one byte per cycle; the crc of a byte is a single combinational
//   pass of eight shift/xor steps between the two registers
// bytes beyond the last device of a frame give no result until the next first
// reset: registers return to their reset values, both stages empty, mask clear
// stall: while a result waits unread the byte in the input register is held and
//   rx.ready drops; it rises again in the cycle res.ready is seen
module daisy_chain_pec15_checker import dcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dcp_rx_if.sink    rx,
    dcp_res_if.source res,
    dcp_cfg_if.sink   cfg
);

    cfg_t              cfg_cur;
    logic              rx_vld_reg;
    logic              rx_first_reg;
    logic [BYTE_W-1:0] rx_byte_reg;
    logic              res_vld_reg;
    result_t           res_reg;
    logic              core_valid;
    result_t           core_res;
    logic              out_free;
    logic              advance;

    dcp_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    dcp_frame_core u_frame_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .first     (rx_first_reg),
        .rx_byte   (rx_byte_reg),
        .cfg       (cfg_cur),
        .res_valid (core_valid),
        .res       (core_res)
    );

    assign out_free = !res_vld_reg || res.ready;
    assign advance  = rx_vld_reg && out_free;
    assign rx.ready = !rx_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (rx.ready)
                rx_vld_reg <= rx.valid;
            if (out_free)
                res_vld_reg <= advance && core_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            rx_first_reg <= rx.first;
            rx_byte_reg  <= rx.rx_byte;
        end
        if (advance && core_valid)
            res_reg <= core_res;
    end

    assign res.valid        = res_vld_reg;
    assign res.ic_index     = res_reg.ic_index;
    assign res.pec_ok       = res_reg.pec_ok;
    assign res.computed_pec = res_reg.computed_pec;
    assign res.error_mask   = res_reg.error_mask;
    assign res.last         = res_reg.last;

`ifndef SYNTHESIS
    // a held byte is never dropped without being processed
    a_rx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_vld_reg && !advance) |=> rx_vld_reg)
        else $error("input register lost a byte");

    // a new result only appears right after a byte was processed
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_vld_reg) |-> $past(advance))
        else $error("result appeared without a processed byte");

    // a failing device is always flagged in the mask it reports
    a_mask_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && !res_reg.pec_ok) |-> res_reg.error_mask[res_reg.ic_index])
        else $error("mismatch not recorded in error mask");
`endif

endmodule

@@ rtl/dcp_cfg_regs.sv @@
// configuration registers with saturation of group length and device count
// depends on dcp_pkg and dcp_cfg_if
module dcp_cfg_regs import dcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dcp_cfg_if.sink   cfg,
    output cfg_t      cfg_out
);

    logic [CRC_W-1:0] poly_reg;
    logic [CRC_W-1:0] seed_reg;
    logic [POS_W-1:0] group_reg;
    logic [DEV_W-1:0] ic_count_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg     <= POLY_RST;
            seed_reg     <= SEED_RST;
            group_reg    <= GROUP_RST;
            ic_count_reg <= IC_COUNT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_POLY:     poly_reg     <= cfg.data;
                CFG_SEED:     seed_reg     <= cfg.data;
                CFG_GROUP:    group_reg    <= cfg.data[POS_W-1:0];
                CFG_IC_COUNT: ic_count_reg <= cfg.data[DEV_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        cfg_out.poly      = poly_reg;
        cfg_out.seed      = seed_reg;
        cfg_out.group_len = (group_reg > POS_W'(MAX_GROUP_BYTES)) ?
                            POS_W'(MAX_GROUP_BYTES) : group_reg;
        cfg_out.ic_count  = (ic_count_reg > DEV_W'(MAX_DEVICES)) ?
                            DEV_W'(MAX_DEVICES) : ic_count_reg;
    end

endmodule

@@ rtl/dcp_frame_core.sv @@
// frame state and single-pass byte processing: crc update, pec capture,
// pec compare and mismatch mask; depends on dcp_pkg
module dcp_frame_core import dcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              first,
    input  logic [BYTE_W-1:0] rx_byte,
    input  cfg_t              cfg,
    output logic              res_valid,
    output result_t           res
);

    logic [CRC_W-1:0]  crc_reg, crc_next, crc_s;
    logic [POS_W-1:0]  pos_reg, pos_next, pos_s;
    logic [DEV_W-1:0]  dev_reg, dev_next, dev_s;
    logic [BYTE_W-1:0] high_reg, high_next, high_s;
    logic [MASK_W-1:0] mask_reg, mask_next, mask_s, mask_upd;
    logic [PEC_W-1:0]  computed;
    logic              ok;

    always_comb
    begin
        // a frame start clears the counters before the byte is handled
        crc_s  = first ? cfg.seed : crc_reg;
        pos_s  = first ? '0 : pos_reg;
        dev_s  = first ? '0 : dev_reg;
        high_s = first ? '0 : high_reg;
        mask_s = first ? '0 : mask_reg;

        computed = {crc_s, 1'b0};
        ok       = (computed == {high_s, rx_byte});
        mask_upd = ok ? mask_s : (mask_s | (MASK_W'(1) << dev_s[IDX_W-1:0]));

        res.ic_index     = dev_s[IDX_W-1:0];
        res.pec_ok       = ok;
        res.computed_pec = computed;
        res.error_mask   = mask_upd;
        res.last         = (DEV_W'(dev_s + 1'b1) == cfg.ic_count);

        crc_next  = crc_s;
        pos_next  = pos_s;
        dev_next  = dev_s;
        high_next = high_s;
        mask_next = mask_s;
        res_valid = 1'b0;

        // past the last device every byte is dropped
        if (dev_s < cfg.ic_count)
        begin
            if (pos_s < cfg.group_len)
            begin
                crc_next = crc_update(crc_s, rx_byte, cfg.poly);
                pos_next = POS_W'(pos_s + 1'b1);
            end
            else if (pos_s == cfg.group_len)
            begin
                high_next = rx_byte;
                pos_next  = POS_W'(pos_s + 1'b1);
            end
            else
            begin
                res_valid = 1'b1;
                mask_next = mask_upd;
                dev_next  = DEV_W'(dev_s + 1'b1);
                pos_next  = '0;
                crc_next  = cfg.seed;
                high_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= SEED_RST;
            pos_reg  <= '0;
            dev_reg  <= '0;
            high_reg <= '0;
            mask_reg <= '0;
        end
        else if (step)
        begin
            crc_reg  <= crc_next;
            pos_reg  <= pos_next;
            dev_reg  <= dev_next;
            high_reg <= high_next;
            mask_reg <= mask_next;
        end
    end

endmodule
